// ----- rtl/core/psg_tone_noise_generator_assert.svh -----
// Assertion macros shared by the sound generator RTL.
`ifndef PSG_TONE_NOISE_GENERATOR_ASSERT_SVH
`define PSG_TONE_NOISE_GENERATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PSG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PSG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/psg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package psg_pkg;

  localparam int unsigned PERIOD_W = 10;
  localparam int unsigned LEVEL_W  = 12;
  localparam int unsigned ATTEN_W  = 4;
  localparam int unsigned SHIFT_W  = 16;

  typedef logic [PERIOD_W-1:0] period_t;
  typedef logic [LEVEL_W-1:0]  level_t;
  typedef logic [ATTEN_W-1:0]  atten_t;
  typedef logic [SHIFT_W-1:0]  shift_t;

  // Register indices carried in bits 6..4 of a latch byte
  localparam logic [2:0] REG_TONE0 = 3'd0;
  localparam logic [2:0] REG_TONE1 = 3'd2;
  localparam logic [2:0] REG_TONE2 = 3'd4;
  localparam logic [2:0] REG_NOISE = 3'd6;
  localparam logic [2:0] REG_RESET = 3'd3;

  localparam logic [1:0]  NOISE_TRACK  = 2'b11;
  localparam shift_t      NOISE_SEED   = 16'h8000;
  localparam period_t     NOISE_BASE   = 10'h010;
  localparam atten_t      ATTEN_SILENT = 4'hF;

  localparam level_t VOL_TABLE [16] = '{
    12'd2800, 12'd2224, 12'd1766, 12'd1403, 12'd1114, 12'd885, 12'd703, 12'd558,
    12'd443,  12'd352,  12'd280,  12'd222,  12'd176,  12'd140, 12'd111, 12'd0
  };

  typedef struct packed {
    logic       tick;
    logic       ctrl_we;
    logic [2:0] ctrl_data;
    logic       tone2_we;
    period_t    tone2_reload;
    period_t    tone2_count;
  } noise_cmd_t;

  function automatic period_t reload_of(input period_t p);
    return (p == '0) ? period_t'(1) : p;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/psg_noise.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "psg_tone_noise_generator_assert.svh"

module psg_noise (
  input  wire                 clk,
  input  wire                 rst_n,
  input  psg_pkg::noise_cmd_t cmd_i,
  output logic                noise_bit_nxt
);
  import psg_pkg::*;

  logic [2:0] ctrl_r,   ctrl_nxt;
  period_t    reload_r, reload_nxt;
  period_t    cnt_r,    cnt_nxt;
  logic       phase_r,  phase_nxt;
  shift_t     shift_r,  shift_nxt;
  logic       fb;

  always_comb begin
    ctrl_nxt   = ctrl_r;
    reload_nxt = reload_r;
    cnt_nxt    = cnt_r;
    phase_nxt  = phase_r;
    shift_nxt  = shift_r;
    fb         = ctrl_r[2] ? (shift_r[0] ^ shift_r[3]) : shift_r[0];
    if (cmd_i.ctrl_we) begin
      ctrl_nxt  = cmd_i.ctrl_data;
      shift_nxt = NOISE_SEED;
      if (cmd_i.ctrl_data[1:0] == NOISE_TRACK) begin
        reload_nxt = cmd_i.tone2_reload;
        cnt_nxt    = cmd_i.tone2_count;
      end else begin
        reload_nxt = NOISE_BASE << cmd_i.ctrl_data[1:0];
      end
    end
    if (cmd_i.tone2_we && ctrl_r[1:0] == NOISE_TRACK) begin
      reload_nxt = cmd_i.tone2_reload;
    end
    if (cmd_i.tick) begin
      if (cnt_r <= period_t'(1)) begin
        cnt_nxt   = reload_r;
        phase_nxt = ~phase_r;
        if (!phase_r) begin
          shift_nxt = {fb, shift_r[SHIFT_W-1:1]};
        end
      end else begin
        cnt_nxt = cnt_r - period_t'(1);
      end
    end
  end

  assign noise_bit_nxt = shift_nxt[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r   <= '0;
      reload_r <= NOISE_BASE;
      cnt_r    <= NOISE_BASE;
      phase_r  <= 1'b1;
      shift_r  <= NOISE_SEED;
    end else begin
      ctrl_r   <= ctrl_nxt;
      reload_r <= reload_nxt;
      cnt_r    <= cnt_nxt;
      phase_r  <= phase_nxt;
      shift_r  <= shift_nxt;
    end
  end

  `PSG_ASSERT_IMP(a_shift_live, 1'b1, shift_r != '0, "noise shifter reached zero")
  `PSG_ASSERT_NXT(a_ctrl_seed, cmd_i.ctrl_we, shift_r == NOISE_SEED, "shifter not reseeded")
  `PSG_ASSERT_IMP(a_cnt_nz, 1'b1, cnt_r != '0 && reload_r != '0, "noise counter at zero")

endmodule

`default_nettype wire

// ----- rtl/core/psg_tone_noise_generator.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "psg_tone_noise_generator_assert.svh"

// Programmable sound generator: three square tone channels and one noise channel.
// Input stream: in_tuser[0] selects the word kind (0 = register byte write,
// 1 = one internal tick), in_tdata[7:0] holds the register byte.
// A write updates the registers and gives no output word. A tick advances
// all four dividers and gives one output word with the four channel levels,
// unsigned, full scale 4096.
// A word is first held in the input register and processed from there; a tick's
// result is registered in the output register and shown on out_tvalid.
// Throughput: one word per cycle unless the receiver stalls, set by the single
// input register and the single output register with all state updated between them.
// When the receiver stalls, the output word holds; writes still pass, and the
// next tick waits in the input register, which then deasserts in_tready.
// After reset: volumes silent, tone periods zero (acting as one), latched
// index three, noise rate 16 ticks, noise shifter 0x8000, all phases high.
module psg_tone_noise_generator (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] data
  input  wire  [0:0]  in_tuser,   // [0] action
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [47:0] out_tdata   // [11:0] tone0, [23:12] tone1, [35:24] tone2, [47:36] noise
);
  import psg_pkg::*;

  logic       in_valid_r;
  logic       action_r;
  logic [7:0] data_r;
  logic       out_valid_r;
  logic [47:0] out_data_r;
  logic       out_free, proc, tick;

  logic [2:0] idx_r, idx_nxt, idx;
  period_t    per_r   [3];
  period_t    per_nxt [3];
  period_t    cnt_r   [3];
  period_t    cnt_nxt [3];
  logic [2:0] phase_r, phase_nxt;
  atten_t     att_r   [4];
  atten_t     att_nxt [4];
  noise_cmd_t ncmd;
  logic       noise_bit_nxt;
  level_t     lvl [4];

  assign out_free  = !out_valid_r || out_tready;
  assign proc      = in_valid_r && (!action_r || out_free);
  assign tick      = proc && action_r;
  assign in_tready = !in_valid_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (proc) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      action_r <= in_tuser[0];
      data_r   <= in_tdata;
    end
  end

  assign idx = data_r[7] ? data_r[6:4] : idx_r;

  always_comb begin
    idx_nxt   = idx_r;
    per_nxt   = per_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    att_nxt   = att_r;
    ncmd      = '0;
    ncmd.tick        = tick;
    ncmd.ctrl_data   = data_r[2:0];
    ncmd.tone2_count = cnt_r[2];
    ncmd.tone2_reload = reload_of(per_r[2]);
    if (proc && !action_r) begin
      idx_nxt = idx;
      if (idx == REG_TONE0 || idx == REG_TONE1 || idx == REG_TONE2) begin
        if (data_r[7]) begin
          per_nxt[idx[2:1]] = {per_r[idx[2:1]][9:4], data_r[3:0]};
        end else begin
          per_nxt[idx[2:1]] = {data_r[5:0], per_r[idx[2:1]][3:0]};
        end
        if (idx == REG_TONE2) begin
          ncmd.tone2_we     = 1'b1;
          ncmd.tone2_reload = reload_of(per_nxt[2]);
        end
      end else if (idx == REG_NOISE) begin
        ncmd.ctrl_we = 1'b1;
      end else begin
        att_nxt[idx[2:1]] = data_r[3:0];
      end
    end
    if (tick) begin
      for (int i = 0; i < 3; i++) begin
        if (cnt_r[i] <= period_t'(1)) begin
          cnt_nxt[i]   = reload_of(per_r[i]);
          phase_nxt[i] = ~phase_r[i];
        end else begin
          cnt_nxt[i] = cnt_r[i] - period_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= REG_RESET;
      phase_r <= '1;
      for (int i = 0; i < 3; i++) begin
        per_r[i] <= '0;
        cnt_r[i] <= period_t'(1);
      end
      for (int i = 0; i < 4; i++) begin
        att_r[i] <= ATTEN_SILENT;
      end
    end else begin
      idx_r   <= idx_nxt;
      per_r   <= per_nxt;
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
      att_r   <= att_nxt;
    end
  end

  psg_noise u_noise (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_i         (ncmd),
    .noise_bit_nxt (noise_bit_nxt)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lvl[i] = phase_nxt[i] ? VOL_TABLE[att_r[i]] : '0;
    end
    lvl[3] = noise_bit_nxt ? VOL_TABLE[att_r[3]] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tick) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      out_data_r <= {lvl[3], lvl[2], lvl[1], lvl[0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `PSG_ASSERT_NXT(a_tick_out, tick, out_valid_r, "tick gave no output word")
  `PSG_ASSERT_IMP(a_cnt_nz, 1'b1, cnt_r[0] != '0 && cnt_r[1] != '0 && cnt_r[2] != '0, "tone counter at zero")
  `PSG_ASSERT_NXT(a_hold_in, in_valid_r && !proc, in_valid_r && $stable(data_r) && $stable(action_r), "pending word lost")

endmodule

`default_nettype wire
